@@ src/cfdq_pkg.sv @@
// Shared constants, request codes and the CRC16-CCITT byte update for the deframer queue
`timescale 1ns / 1ps

package cfdq_pkg;

  // default sizes
  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int QUEUE_LEN_DEF   = 4;

  // configuration reset value
  localparam logic [7:0] START_BYTE_RESET = 8'hA5;

  // crc16-ccitt, msb first, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // request codes
  localparam logic [2:0] REQ_BYTE       = 3'd0;
  localparam logic [2:0] REQ_READ       = 3'd1;
  localparam logic [2:0] REQ_POP        = 3'd2;
  localparam logic [2:0] REQ_CLEAR      = 3'd3;
  localparam logic [2:0] REQ_PARSER_RST = 3'd4;

  // one byte through the crc register, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ src/cfdq_store.sv @@
// Frame storage: payload byte memory and per-slot header memory, both with registered read
`timescale 1ns / 1ps

module cfdq_store #(
  parameter int QUEUE_LEN = 4,
  parameter int OFF_W     = 8,
  parameter int LEN_W     = 9
) (
  input  logic                                clk,
  // payload write and read
  input  logic                                pay_we,
  input  logic [$clog2(QUEUE_LEN)+OFF_W-1:0]  pay_waddr,
  input  logic [7:0]                          pay_wdata,
  input  logic                                pay_re,
  input  logic [$clog2(QUEUE_LEN)+OFF_W-1:0]  pay_raddr,
  output logic [7:0]                          pay_rdata,
  // slot header: version, sequence, length
  input  logic                                meta_we,
  input  logic [$clog2(QUEUE_LEN)-1:0]        meta_waddr,
  input  logic [16+LEN_W-1:0]                 meta_wdata,
  input  logic                                meta_re,
  input  logic [$clog2(QUEUE_LEN)-1:0]        meta_raddr,
  output logic [16+LEN_W-1:0]                 meta_rdata
);

  localparam int PAY_DEPTH = QUEUE_LEN * (2 ** OFF_W);
  localparam int META_W    = 16 + LEN_W;

  logic [7:0]        pay_mem  [PAY_DEPTH];
  logic [META_W-1:0] meta_mem [QUEUE_LEN];

  // payload memory; the slot being filled is never a queued slot, so no bypass
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (pay_re) begin
      pay_rdata <= pay_mem[pay_raddr];
    end
  end

  // header memory with write-to-read bypass for a frame queued in the same beat
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      if (meta_we && (meta_waddr == meta_raddr)) begin
        meta_rdata <= meta_wdata;
      end else begin
        meta_rdata <= meta_mem[meta_raddr];
      end
    end
  end

endmodule

@@ src/crc16_frame_deframer_queue.sv @@
// Top level: start/length/CRC16 frame parser feeding a circular queue of received frames
`timescale 1ns / 1ps

// Takes one request beat per clock with no bubbles while in_stall is low; each beat gives
// exactly one result beat, which passes the first stage register (the accepting edge updates
// the parser and queue and starts the synchronous memory read) and then the output register, and
// sustains one result per cycle as long as out_stall stays low. Received frames live in a
// payload memory of QUEUE_LEN slots of 2**ceil(log2(MAX_PAYLOAD)) bytes and a header memory
// of QUEUE_LEN entries; at most QUEUE_LEN-1 frames are queued. The memories need no clearing
// after reset, so the block accepts requests from the first cycle out of reset. start_byte is
// written through the cfg port (always ready) and must only change while the block is idle.
module crc16_frame_deframer_queue
  import cfdq_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_LEN   = QUEUE_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_req_type,
  input  logic [7:0]                         in_data_byte,
  input  logic [7:0]                         in_byte_index,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_frame_done,
  output logic                               out_crc_mismatch,
  output logic                               out_length_too_big,
  output logic                               out_queue_overflow,
  output logic                               out_queue_empty,
  output logic [$clog2(QUEUE_LEN)-1:0]       out_queue_count,
  output logic [7:0]                         out_head_version,
  output logic [7:0]                         out_head_sequence,
  output logic [$clog2(MAX_PAYLOAD+1)-1:0]   out_head_length,
  output logic [7:0]                         out_head_data
);

  localparam int SLOT_W = $clog2(QUEUE_LEN);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int OFF_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int META_W = 16 + LEN_W;

  // parser phases
  localparam logic [2:0] PH_SOF = 3'd0;
  localparam logic [2:0] PH_VER = 3'd1;
  localparam logic [2:0] PH_SEQ = 3'd2;
  localparam logic [2:0] PH_LHI = 3'd3;
  localparam logic [2:0] PH_LLO = 3'd4;
  localparam logic [2:0] PH_PAY = 3'd5;
  localparam logic [2:0] PH_CHI = 3'd6;
  localparam logic [2:0] PH_CLO = 3'd7;

  // configuration and parser state
  logic [7:0]        start_byte_r;
  logic [2:0]        phase_r, phase_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0]  rcv_cnt_r, rcv_cnt_nxt;
  logic [7:0]        crc_hi_r, crc_hi_nxt;
  logic [7:0]        ver_r, ver_nxt;
  logic [7:0]        seq_r, seq_nxt;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r, rs_nxt;

  // first stage, memory read in flight
  logic              p_valid_r;
  logic              p_done_r, p_mis_r, p_big_r, p_ovf_r;
  logic [SLOT_W-1:0] p_used_r;
  logic [7:0]        p_idx_r;

  // output register
  logic              out_valid_r;
  logic              out_done_r, out_mis_r, out_big_r, out_ovf_r, out_empty_r;
  logic [SLOT_W-1:0] out_count_r;
  logic [7:0]        out_ver_r, out_seq_r, out_data_r;
  logic [LEN_W-1:0]  out_len_r;

  // handshake
  logic              out_free, p_adv, accept;

  // beat flags and store access
  logic              f_done, f_mis, f_big, f_ovf;
  logic              pay_we, meta_we;
  logic [SLOT_W-1:0] ws_inc, rs_inc, used_cur, used_post;
  logic [15:0]       len_full, crc_upd;
  logic [LEN_W-1:0]  rcv_inc;
  logic [7:0]        pay_rdata;
  logic [META_W-1:0] meta_rdata;

  // head fields at the first stage
  logic              p_empty;
  logic [7:0]        h_ver, h_seq, h_data;
  logic [LEN_W-1:0]  h_len;

  function automatic logic [SLOT_W-1:0] slot_used(input logic [SLOT_W-1:0] w,
                                                   input logic [SLOT_W-1:0] r);
    logic [SLOT_W-1:0] wrap;
    wrap = (w < r) ? SLOT_W'(QUEUE_LEN) : '0;
    return w - r + wrap;
  endfunction

  assign cfg_ready = 1'b1;

  // handshake: first stage moves on when the output register is free
  assign out_free = !out_valid_r || !out_stall;
  assign p_adv    = p_valid_r && out_free;
  assign in_stall = p_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // slot arithmetic
  assign ws_inc    = (ws_r == SLOT_W'(QUEUE_LEN - 1)) ? '0 : ws_r + SLOT_W'(1);
  assign rs_inc    = (rs_r == SLOT_W'(QUEUE_LEN - 1)) ? '0 : rs_r + SLOT_W'(1);
  assign used_cur  = slot_used(ws_r, rs_r);
  assign used_post = slot_used(ws_nxt, rs_nxt);

  assign crc_upd  = crc16_byte(crc_r, in_data_byte);
  assign len_full = {exp_len_r[15:8], in_data_byte};
  assign rcv_inc  = rcv_cnt_r + LEN_W'(1);

  // parser and queue pointer update for the accepted beat
  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    exp_len_nxt = exp_len_r;
    rcv_cnt_nxt = rcv_cnt_r;
    crc_hi_nxt  = crc_hi_r;
    ver_nxt     = ver_r;
    seq_nxt     = seq_r;
    ws_nxt      = ws_r;
    rs_nxt      = rs_r;
    f_done      = 1'b0;
    f_mis       = 1'b0;
    f_big       = 1'b0;
    f_ovf       = 1'b0;
    pay_we      = 1'b0;
    meta_we     = 1'b0;
    if (accept) begin
      case (in_req_type)
        REQ_BYTE: begin
          case (phase_r)
            PH_SOF: begin
              if (in_data_byte == start_byte_r) begin
                crc_nxt   = crc16_byte(CRC_INIT, in_data_byte);
                phase_nxt = PH_VER;
              end
            end
            PH_VER: begin
              ver_nxt   = in_data_byte;
              crc_nxt   = crc_upd;
              phase_nxt = PH_SEQ;
            end
            PH_SEQ: begin
              seq_nxt   = in_data_byte;
              crc_nxt   = crc_upd;
              phase_nxt = PH_LHI;
            end
            PH_LHI: begin
              exp_len_nxt = {in_data_byte, 8'h00};
              crc_nxt     = crc_upd;
              phase_nxt   = PH_LLO;
            end
            PH_LLO: begin
              exp_len_nxt = len_full;
              crc_nxt     = crc_upd;
              if (32'(len_full) > MAX_PAYLOAD) begin
                f_big     = 1'b1;
                phase_nxt = PH_SOF;
              end else begin
                rcv_cnt_nxt = '0;
                phase_nxt   = (len_full == 16'd0) ? PH_CHI : PH_PAY;
              end
            end
            PH_PAY: begin
              pay_we      = 1'b1;
              rcv_cnt_nxt = rcv_inc;
              crc_nxt     = crc_upd;
              if (32'(rcv_inc) >= 32'(exp_len_r)) begin
                phase_nxt = PH_CHI;
              end
            end
            PH_CHI: begin
              crc_hi_nxt = in_data_byte;
              phase_nxt  = PH_CLO;
            end
            default: begin
              phase_nxt = PH_SOF;
              if ({crc_hi_r, in_data_byte} != crc_r) begin
                f_mis = 1'b1;
              end else if (ws_inc == rs_r) begin
                f_ovf = 1'b1;
              end else begin
                meta_we = 1'b1;
                ws_nxt  = ws_inc;
                f_done  = 1'b1;
              end
            end
          endcase
        end
        REQ_READ: begin
        end
        REQ_POP: begin
          if (used_cur != '0) begin
            rs_nxt = rs_inc;
          end
        end
        REQ_CLEAR: begin
          rs_nxt = ws_r;
        end
        REQ_PARSER_RST: begin
          phase_nxt   = PH_SOF;
          crc_nxt     = CRC_INIT;
          exp_len_nxt = '0;
          rcv_cnt_nxt = '0;
          crc_hi_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // frame storage
  cfdq_store #(
    .QUEUE_LEN (QUEUE_LEN),
    .OFF_W     (OFF_W),
    .LEN_W     (LEN_W)
  ) u_store (
    .clk        (clk),
    .pay_we     (pay_we),
    .pay_waddr  ({ws_r, rcv_cnt_r[OFF_W-1:0]}),
    .pay_wdata  (in_data_byte),
    .pay_re     (accept),
    .pay_raddr  ({rs_nxt, OFF_W'(in_byte_index)}),
    .pay_rdata  (pay_rdata),
    .meta_we    (meta_we),
    .meta_waddr (ws_r),
    .meta_wdata ({ver_r, seq_r, exp_len_r[LEN_W-1:0]}),
    .meta_re    (accept),
    .meta_raddr (rs_nxt),
    .meta_rdata (meta_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RESET;
      phase_r      <= PH_SOF;
      crc_r        <= CRC_INIT;
      exp_len_r    <= '0;
      rcv_cnt_r    <= '0;
      crc_hi_r     <= '0;
      ws_r         <= '0;
      rs_r         <= '0;
      p_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_byte_r <= cfg_data;
      end
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      exp_len_r <= exp_len_nxt;
      rcv_cnt_r <= rcv_cnt_nxt;
      crc_hi_r  <= crc_hi_nxt;
      ws_r      <= ws_nxt;
      rs_r      <= rs_nxt;
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (p_adv) begin
        p_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  // frame header capture and first stage payload
  always_ff @(posedge clk) begin
    ver_r <= ver_nxt;
    seq_r <= seq_nxt;
    if (accept) begin
      p_done_r <= f_done;
      p_mis_r  <= f_mis;
      p_big_r  <= f_big;
      p_ovf_r  <= f_ovf;
      p_used_r <= used_post;
      p_idx_r  <= in_byte_index;
    end
  end

  // head fields from the memory read
  assign p_empty = (p_used_r == '0);
  assign h_ver   = p_empty ? 8'h00 : meta_rdata[META_W-1 -: 8];
  assign h_seq   = p_empty ? 8'h00 : meta_rdata[LEN_W+7 -: 8];
  assign h_len   = p_empty ? '0 : meta_rdata[LEN_W-1:0];
  assign h_data  = (!p_empty && (32'(p_idx_r) < 32'(h_len))) ? pay_rdata : 8'h00;

  // output register
  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_done_r  <= p_done_r;
      out_mis_r   <= p_mis_r;
      out_big_r   <= p_big_r;
      out_ovf_r   <= p_ovf_r;
      out_empty_r <= p_empty;
      out_count_r <= p_used_r;
      out_ver_r   <= h_ver;
      out_seq_r   <= h_seq;
      out_len_r   <= h_len;
      out_data_r  <= h_data;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_done     = out_done_r;
  assign out_crc_mismatch   = out_mis_r;
  assign out_length_too_big = out_big_r;
  assign out_queue_overflow = out_ovf_r;
  assign out_queue_empty    = out_empty_r;
  assign out_queue_count    = out_count_r;
  assign out_head_version   = out_ver_r;
  assign out_head_sequence  = out_seq_r;
  assign out_head_length    = out_len_r;
  assign out_head_data      = out_data_r;

`ifndef SYNTHESIS
  // slot pointers stay inside the queue
  a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(ws_r) < QUEUE_LEN) && (32'(rs_r) < QUEUE_LEN))
    else $error("queue slot pointer out of range");

  // a queued frame leaves the queue non-empty
  a_done_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_empty_r)
    else $error("frame queued but queue reported empty");

  // overflow only reported with a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (32'(out_count_r) == QUEUE_LEN - 1))
    else $error("overflow reported with room in the queue");

  // a pop on a non-empty queue moves the read slot
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_POP) && (used_cur != '0)) |=> (rs_r != $past(rs_r)))
    else $error("pop did not advance read slot");

  // stage content is not dropped while the output is stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && out_valid_r && out_stall) |=> p_valid_r)
    else $error("first stage beat lost under stall");
`endif

endmodule
